/* rtl/power_switch_sequencer_unit_assert.svh */
// Assertion macros used by the file that checks its own logic.
`ifndef POWER_SWITCH_SEQUENCER_UNIT_ASSERT_SVH
`define POWER_SWITCH_SEQUENCER_UNIT_ASSERT_SVH

// The property must hold in the same cycle as its condition.
`define PSS_ASSERT_SAME(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error(msg);

// The property must hold in the cycle after its condition.
`define PSS_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error(msg);

`endif

/* rtl/pss_pkg.sv */
`timescale 1ns / 1ps

package pss_pkg;

   localparam int TickBits = 16;
   localparam int CfgBits = 16;
   localparam int CmpBits = (TickBits > CfgBits) ? TickBits : CfgBits;
   localparam int CsrIndexBits = 2;
   localparam int PhaseBits = 2;
   localparam int ReqDataBits = 24;
   localparam int RspDataBits = 8;

   localparam logic [TickBits-1:0] TickTop = {TickBits{1'b1}};

   localparam logic [CfgBits-1:0] MinStateDelayReset = 16'd2500;
   localparam logic [CfgBits-1:0] ForcedOffHoldReset = 16'd5000;
   localparam logic [CfgBits-1:0] MaxShutdownWaitReset = 16'd30000;

   localparam logic [CsrIndexBits-1:0] CsrMinStateDelay = 2'd0;
   localparam logic [CsrIndexBits-1:0] CsrForcedOffHold = 2'd1;
   localparam logic [CsrIndexBits-1:0] CsrMaxShutdownWait = 2'd2;

   localparam logic [PhaseBits-1:0] PhaseCodeOff = 2'd0;
   localparam logic [PhaseBits-1:0] PhaseCodeBoot = 2'd1;
   localparam logic [PhaseBits-1:0] PhaseCodeOn = 2'd2;
   localparam logic [PhaseBits-1:0] PhaseCodeShut = 2'd3;

   typedef struct packed {
      logic [CfgBits-1:0] min_state_delay;
      logic [CfgBits-1:0] forced_off_hold;
      logic [CfgBits-1:0] max_shutdown_wait;
   } cfg_type;

   typedef struct packed {
      logic        button_down;
      logic [15:0] button_hold_ticks;
      logic        host_active;
   } item_type;

   typedef struct packed {
      logic                 power_enable;
      logic                 shutdown_request;
      logic [PhaseBits-1:0] phase;
   } result_type;

   typedef struct packed {
      logic momentary_mode;
      logic released_once;
   } status_type;

endpackage

/* rtl/power_switch_sequencer_unit.sv */
`timescale 1ns / 1ps
// Power switch sequencer. Each request is one system tick carrying the button
// level, the button hold time and the host power status; each yields exactly
// one response with the power enable, the shutdown request and the phase code.
// Requests enter on the req_ stream, responses leave on the rsp_ stream, and
// the three timing registers are written through the csr_ port. The user must
// write them only while the block is idle; the block does not enforce this.
// A request accepted from req_ is held in the input register, and its
// response becomes valid once the output can advance, when the sequence
// state is updated and the result register is loaded.
// Throughput is one request per cycle while the receiver does not stall; the
// state update loop sets that figure.
// Reset clears both stages, puts the sequence in the off phase with a zero
// counter and latching mode, and restores the register defaults.
// When the receiver stalls, the response is held, the input register keeps
// its request, and req_tready falls once both are full.

`include "power_switch_sequencer_unit_assert.svh"

module power_switch_sequencer_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // [0] button_down, [16:1] button_hold_ticks, [17] host_active, rest zero
   input  logic [pss_pkg::ReqDataBits-1:0]  req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [0] power_enable, [1] shutdown_request, [3:2] phase, rest zero
   output logic [pss_pkg::RspDataBits-1:0]  rsp_tdata,
   input  logic                             csr_wr_en,
   input  logic [pss_pkg::CsrIndexBits-1:0] csr_index,
   input  logic [pss_pkg::CfgBits-1:0]      csr_wdata
);

   pss_pkg::cfg_type    cfg;
   pss_pkg::item_type   req_item;
   pss_pkg::item_type   item;
   pss_pkg::result_type result;
   pss_pkg::status_type status;
   pss_pkg::result_type result_ff;
   pss_pkg::result_type result_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic                item_valid;
   logic                advance;
   logic                step;

   assign req_item.button_down = req_tdata[0];
   assign req_item.button_hold_ticks = req_tdata[16:1];
   assign req_item.host_active = req_tdata[17];

   assign advance = !rsp_valid_ff || rsp_tready;
   assign step = advance && item_valid;

   pss_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   pss_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_item   (req_item),
      .advance    (advance),
      .req_ready  (req_tready),
      .item_valid (item_valid),
      .item       (item)
   );

   pss_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .item   (item),
      .cfg    (cfg),
      .result (result),
      .status (status)
   );

   always_comb begin
      rsp_valid_in = advance ? item_valid : rsp_valid_ff;
      result_in = step ? result : result_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {4'b0000, result_ff.phase, result_ff.shutdown_request,
                       result_ff.power_enable};

   `PSS_ASSERT_SAME(a_no_overrun, clock, reset, req_tvalid && req_tready && item_valid,
      advance, "request accepted into a full input register that does not advance")
   `PSS_ASSERT_NEXT(a_stall_keeps_item, clock, reset,
      item_valid && rsp_valid_ff && !rsp_tready,
      item_valid, "input register lost its request during an output stall")
   `PSS_ASSERT_NEXT(a_mode_sticky, clock, reset, status.momentary_mode,
      status.momentary_mode, "momentary mode cleared without reset")
   `PSS_ASSERT_SAME(a_enable_matches_phase, clock, reset, rsp_valid_ff,
      result_ff.power_enable == (result_ff.phase != pss_pkg::PhaseCodeOff),
      "power enable disagrees with the phase code")

endmodule

/* rtl/pss_csr.sv */
`timescale 1ns / 1ps

module pss_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [pss_pkg::CsrIndexBits-1:0] csr_index,
   input  logic [pss_pkg::CfgBits-1:0]      csr_wdata,
   output pss_pkg::cfg_type                 cfg
);

   pss_pkg::cfg_type cfg_ff;
   pss_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            pss_pkg::CsrMinStateDelay:   cfg_in.min_state_delay = csr_wdata;
            pss_pkg::CsrForcedOffHold:   cfg_in.forced_off_hold = csr_wdata;
            pss_pkg::CsrMaxShutdownWait: cfg_in.max_shutdown_wait = csr_wdata;
            default:                     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_state_delay <= pss_pkg::MinStateDelayReset;
         cfg_ff.forced_off_hold <= pss_pkg::ForcedOffHoldReset;
         cfg_ff.max_shutdown_wait <= pss_pkg::MaxShutdownWaitReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* rtl/pss_in_stage.sv */
`timescale 1ns / 1ps

module pss_in_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  pss_pkg::item_type req_item,
   input  logic              advance,
   output logic              req_ready,
   output logic              item_valid,
   output pss_pkg::item_type item
);

   logic              valid_ff;
   logic              valid_in;
   pss_pkg::item_type item_ff;
   pss_pkg::item_type item_in;
   logic              accept;

   assign req_ready = !valid_ff || advance;
   assign accept = req_valid && req_ready;

   always_comb begin
      item_in = accept ? req_item : item_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item = item_ff;

endmodule

/* rtl/pss_core.sv */
`timescale 1ns / 1ps

module pss_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  pss_pkg::item_type   item,
   input  pss_pkg::cfg_type    cfg,
   output pss_pkg::result_type result,
   output pss_pkg::status_type status
);

   typedef enum logic [3:0] {
      PhOff  = 4'b0001,
      PhBoot = 4'b0010,
      PhOn   = 4'b0100,
      PhShut = 4'b1000
   } phase_type;

   phase_type                     phase_ff;
   phase_type                     phase_in;
   logic [pss_pkg::TickBits-1:0]  ticks_ff;
   logic [pss_pkg::TickBits-1:0]  ticks_in;
   logic                          released_ff;
   logic                          released_in;
   logic                          mode_ff;
   logic                          mode_in;
   logic                          long_press;
   logic                          delay_done;
   logic                          wait_done;
   logic [pss_pkg::PhaseBits-1:0] phase_code;

   assign long_press = item.button_down
                       && (item.button_hold_ticks > cfg.forced_off_hold);
   assign delay_done = pss_pkg::CmpBits'(ticks_ff)
                       >= pss_pkg::CmpBits'(cfg.min_state_delay);
   assign wait_done = pss_pkg::CmpBits'(ticks_ff)
                      >= pss_pkg::CmpBits'(cfg.max_shutdown_wait);

   // Later moves override earlier ones within one tick.
   always_comb begin
      phase_in = phase_ff;
      released_in = released_ff;
      mode_in = mode_ff;
      unique case (phase_ff)
         PhOff: begin
            if (!item.button_down) begin
               released_in = 1'b1;
            end
            if ((!mode_ff || released_in) && (item.button_down || item.host_active)) begin
               phase_in = PhBoot;
            end
         end
         PhBoot: begin
            if (item.host_active && delay_done) begin
               phase_in = PhOn;
            end
            if (!item.button_down && !delay_done) begin
               mode_in = 1'b1;
            end
            if (mode_in && long_press) begin
               phase_in = PhOff;
            end
         end
         PhOn: begin
            if (mode_ff) begin
               if (item.button_down || !item.host_active) begin
                  phase_in = PhShut;
               end
            end else begin
               if (!item.button_down || !item.host_active) begin
                  phase_in = PhShut;
               end
            end
         end
         PhShut: begin
            if (!item.host_active && delay_done) begin
               phase_in = PhOff;
            end
            if (mode_ff && long_press) begin
               phase_in = PhOff;
            end
            if (!mode_ff && wait_done) begin
               phase_in = PhOff;
            end
         end
         default: begin
            phase_in = PhOff;
         end
      endcase

      if (phase_in != phase_ff) begin
         ticks_in = '0;
         if (phase_in == PhOff) begin
            released_in = 1'b0;
         end
      end else if (ticks_ff != pss_pkg::TickTop) begin
         ticks_in = ticks_ff + 1'b1;
      end else begin
         ticks_in = ticks_ff;
      end
   end

   always_comb begin
      unique case (phase_in)
         PhOff:   phase_code = pss_pkg::PhaseCodeOff;
         PhBoot:  phase_code = pss_pkg::PhaseCodeBoot;
         PhOn:    phase_code = pss_pkg::PhaseCodeOn;
         PhShut:  phase_code = pss_pkg::PhaseCodeShut;
         default: phase_code = pss_pkg::PhaseCodeOff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PhOff;
         ticks_ff <= '0;
         released_ff <= 1'b0;
         mode_ff <= 1'b0;
      end else if (step) begin
         phase_ff <= phase_in;
         ticks_ff <= ticks_in;
         released_ff <= released_in;
         mode_ff <= mode_in;
      end
   end

   assign result.power_enable = (phase_in != PhOff);
   assign result.shutdown_request = (phase_in == PhShut);
   assign result.phase = phase_code;
   assign status.momentary_mode = mode_ff;
   assign status.released_once = released_ff;

endmodule
